>>> hw/rtl/bap_pkg.sv
// Shared types and constants for the buddy page allocator.
package bap_pkg;

  localparam int PAGE_COUNT_DEF  = 4096;
  localparam int ORDER_COUNT_DEF = 11;

  localparam int REG_W   = 13;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_REGION_FIRST = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_END   = 1'd1;

  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [3:0]  block_order;
    logic [11:0] free_page;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [11:0] granted_page;
  } out_item_t;

  typedef enum logic [4:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_I_STEP,
    ST_A_START,
    ST_A_SPLIT,
    ST_F_START,
    ST_F_CHK,
    ST_F_LOOP,
    ST_F_BCHK,
    ST_F_LINK,
    ST_U_RD,
    ST_U_GET,
    ST_U_PRD,
    ST_U_PWR,
    ST_U_NRD,
    ST_U_NWR,
    ST_L_RD,
    ST_L_CHK,
    ST_L_XRD,
    ST_L_XWR,
    ST_RESP
  } state_t;

endpackage

>>> hw/rtl/bap_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module bap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/buddy_page_allocator_unit.sv
// Buddy page allocator: free lists of aligned power-of-two page blocks kept in one page RAM.
//
// Every page has one RAM word holding its free mark, block order and the two list links;
// the list ends per order sit in registers. All work is done by a sequencer that reads a
// word, then writes it back, so one item is in work at a time. After reset a clearing pass
// writes every page word before the first item is taken. Every item is taken in the idle
// state and then hands its result to the output register. An init item repeats the clearing
// pass, then carves the region into the largest aligned blocks that fit and puts each on
// its order's list. An allocate takes the head block off the smallest non-empty list at or
// above the asked order, then splits it down, putting each upper half on its list (taking
// it off its list first where it is still on one). A free first takes the page off its
// list if it is already on one, then merges it with each free buddy of the same order and
// links the resulting block. Results leave through an output register, so a new item is
// taken while a result waits.
module buddy_page_allocator_unit #(
  parameter int PAGE_COUNT  = bap_pkg::PAGE_COUNT_DEF,
  parameter int ORDER_COUNT = bap_pkg::ORDER_COUNT_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  bap_pkg::in_item_t                in_item,
  output logic                             out_valid,
  input  logic                             out_stall,
  output bap_pkg::out_item_t               out_item,
  input  logic                             cfg_write,
  input  logic [bap_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bap_pkg::REG_W-1:0]        cfg_data
);

  localparam int AW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int PW = $clog2(PAGE_COUNT + 1);
  localparam int OW = $clog2(ORDER_COUNT + 1);
  localparam int XW = (ORDER_COUNT > 1) ? $clog2(ORDER_COUNT) : 1;
  localparam logic [PW-1:0] NIL = PW'(PAGE_COUNT);
  localparam logic [AW-1:0] LAST_ADDR = AW'(PAGE_COUNT - 1);

  typedef struct packed {
    logic          mark;
    logic [OW-1:0] tag;
    logic [PW-1:0] nx;
    logic [PW-1:0] pr;
  } page_word_t;

  localparam int MW = $bits(page_word_t);

  // Configuration.
  logic [bap_pkg::REG_W-1:0] region_first, region_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      region_first <= '0;
      region_end   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        bap_pkg::CFG_REGION_FIRST: region_first <= cfg_data;
        bap_pkg::CFG_REGION_END:   region_end   <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [PW-1:0] start_c, end_c;
  assign start_c = (int'(region_first) >= PAGE_COUNT) ? NIL : PW'(region_first);
  assign end_c   = (int'(region_end) >= PAGE_COUNT) ? NIL : PW'(region_end);

  // Page RAM.
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  page_word_t    ram_wdata, rd;
  logic [MW-1:0] ram_rdata;

  bap_ram #(.WIDTH(MW), .DEPTH(PAGE_COUNT)) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd = page_word_t'(ram_rdata);

  // List ends per order.
  logic [PW-1:0] head [ORDER_COUNT];
  logic [PW-1:0] tail [ORDER_COUNT];
  logic          hd_we, tl_we, ends_clr;
  logic [XW-1:0] hd_idx, tl_idx;
  logic [PW-1:0] hd_val, tl_val;

  always_ff @(posedge clk) begin
    if (rst || ends_clr) begin
      for (int i = 0; i < ORDER_COUNT; i++) begin
        head[i] <= NIL;
        tail[i] <= NIL;
      end
    end else begin
      if (hd_we) begin
        head[hd_idx] <= hd_val;
      end
      if (tl_we) begin
        tail[tl_idx] <= tl_val;
      end
    end
  end

  // Sequencer registers.
  bap_pkg::state_t st, st_next, uret, uret_next, lret, lret_next;
  logic [1:0]    req, req_next;
  logic          arg_ok, arg_ok_next;
  logic [OW-1:0] ord, ord_next, cur, cur_next, lo, lo_next;
  logic [PW-1:0] page, page_next, bud, bud_next, idx, idx_next;
  logic [PW-1:0] up, up_next, upr, upr_next, unx, unx_next;
  logic [PW-1:0] lp, lp_next, lx, lx_next;
  logic          lt, lt_next;
  logic [AW-1:0] cnt, cnt_next;
  logic          clr_init, clr_init_next;
  logic          res_status, res_status_next;
  logic [11:0]   res_page, res_page_next;
  logic          out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      st       <= bap_pkg::ST_CLEAR;
      cnt      <= '0;
      clr_init <= 1'b0;
    end else begin
      st       <= st_next;
      cnt      <= cnt_next;
      clr_init <= clr_init_next;
    end
    uret       <= uret_next;
    lret       <= lret_next;
    req        <= req_next;
    arg_ok     <= arg_ok_next;
    ord        <= ord_next;
    cur        <= cur_next;
    lo         <= lo_next;
    page       <= page_next;
    bud        <= bud_next;
    idx        <= idx_next;
    up         <= up_next;
    upr        <= upr_next;
    unx        <= unx_next;
    lp         <= lp_next;
    lx         <= lx_next;
    lt         <= lt_next;
    res_status <= res_status_next;
    res_page   <= res_page_next;
  end

  // Largest aligned block that fits at idx.
  logic [OW-1:0] init_ord;
  always_comb begin
    int rem;
    rem = int'(end_c) - int'(idx);
    init_ord = '0;
    for (int o = 1; o < ORDER_COUNT; o++) begin
      if (rem >= (1 << o) && (int'(idx) & ((1 << o) - 1)) == 0) begin
        init_ord = OW'(o);
      end
    end
  end

  // Smallest non-empty order at or above the request.
  logic          found;
  logic [OW-1:0] found_ord;
  always_comb begin
    found     = 1'b0;
    found_ord = '0;
    for (int c = ORDER_COUNT - 1; c >= 0; c--) begin
      if (c >= int'(ord) && head[c] != NIL) begin
        found     = 1'b1;
        found_ord = OW'(c);
      end
    end
  end

  assign in_stall = (st != bap_pkg::ST_IDLE);

  always_comb begin
    page_word_t w;
    int         b;
    logic [OW-1:0] c;
    logic [PW-1:0] x;
    w = rd;
    b = 0;
    c = '0;
    x = '0;

    st_next         = st;
    uret_next       = uret;
    lret_next       = lret;
    req_next        = req;
    arg_ok_next     = arg_ok;
    ord_next        = ord;
    cur_next        = cur;
    lo_next         = lo;
    page_next       = page;
    bud_next        = bud;
    idx_next        = idx;
    up_next         = up;
    upr_next        = upr;
    unx_next        = unx;
    lp_next         = lp;
    lx_next         = lx;
    lt_next         = lt;
    cnt_next        = cnt;
    clr_init_next   = clr_init;
    res_status_next = res_status;
    res_page_next   = res_page;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_raddr = '0;
    hd_we     = 1'b0;
    hd_idx    = '0;
    hd_val    = '0;
    tl_we     = 1'b0;
    tl_idx    = '0;
    tl_val    = '0;
    ends_clr  = 1'b0;
    out_load  = 1'b0;

    case (st)
      bap_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt;
        ram_wdata = '0;
        cnt_next  = cnt + AW'(1);
        if (cnt == LAST_ADDR) begin
          cnt_next = '0;
          st_next  = clr_init ? bap_pkg::ST_I_STEP : bap_pkg::ST_IDLE;
        end
      end

      bap_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_next        = in_item.req_type;
          ord_next        = OW'(in_item.block_order);
          page_next       = PW'(in_item.free_page);
          res_status_next = 1'b0;
          res_page_next   = '0;
          case (in_item.req_type)
            bap_pkg::REQ_INIT: begin
              ends_clr      = 1'b1;
              idx_next      = start_c;
              clr_init_next = 1'b1;
              cnt_next      = '0;
              st_next       = bap_pkg::ST_CLEAR;
            end
            bap_pkg::REQ_ALLOC: begin
              arg_ok_next = int'(in_item.block_order) < ORDER_COUNT;
              st_next     = bap_pkg::ST_A_START;
            end
            bap_pkg::REQ_FREE: begin
              arg_ok_next = int'(in_item.block_order) < ORDER_COUNT &&
                            int'(in_item.free_page) < PAGE_COUNT;
              st_next     = bap_pkg::ST_F_START;
            end
            default: st_next = bap_pkg::ST_RESP;
          endcase
        end
      end

      bap_pkg::ST_I_STEP: begin
        if (idx < end_c) begin
          lp_next   = idx;
          lo_next   = init_ord;
          lt_next   = 1'b1;
          lret_next = bap_pkg::ST_I_STEP;
          idx_next  = PW'(int'(idx) + (1 << init_ord));
          st_next   = bap_pkg::ST_L_RD;
        end else begin
          st_next = bap_pkg::ST_RESP;
        end
      end

      bap_pkg::ST_A_START: begin
        if (!arg_ok || !found) begin
          res_status_next = 1'b1;
          st_next         = bap_pkg::ST_RESP;
        end else begin
          page_next = head[found_ord[XW-1:0]];
          up_next   = head[found_ord[XW-1:0]];
          cur_next  = found_ord;
          uret_next = bap_pkg::ST_A_SPLIT;
          st_next   = bap_pkg::ST_U_RD;
        end
      end

      bap_pkg::ST_A_SPLIT: begin
        if (cur > ord) begin
          c        = cur - OW'(1);
          cur_next = c;
          b        = int'(page) ^ (1 << c);
          if (b < PAGE_COUNT) begin
            lp_next   = PW'(b);
            lo_next   = c;
            lt_next   = 1'b0;
            lret_next = bap_pkg::ST_A_SPLIT;
            st_next   = bap_pkg::ST_L_RD;
          end
        end else begin
          res_page_next = 12'(page);
          st_next       = bap_pkg::ST_RESP;
        end
      end

      bap_pkg::ST_F_START: begin
        if (!arg_ok) begin
          st_next = bap_pkg::ST_RESP;
        end else begin
          ram_raddr = page[AW-1:0];
          st_next   = bap_pkg::ST_F_CHK;
        end
      end

      bap_pkg::ST_F_CHK: begin
        if (rd.mark) begin
          up_next   = page;
          uret_next = bap_pkg::ST_F_LOOP;
          st_next   = bap_pkg::ST_U_RD;
        end else begin
          st_next = bap_pkg::ST_F_LOOP;
        end
      end

      bap_pkg::ST_F_LOOP: begin
        st_next = bap_pkg::ST_F_LINK;
        if (int'(ord) < ORDER_COUNT - 1) begin
          b = int'(page) ^ (1 << ord);
          if (b < PAGE_COUNT) begin
            bud_next  = PW'(b);
            ram_raddr = AW'(b);
            st_next   = bap_pkg::ST_F_BCHK;
          end
        end
      end

      bap_pkg::ST_F_BCHK: begin
        if (!rd.mark || rd.tag != ord) begin
          st_next = bap_pkg::ST_F_LINK;
        end else begin
          // The buddy is free at the same order: absorb it and try one order up.
          if (bud < page) begin
            page_next = bud;
          end
          ord_next  = ord + OW'(1);
          up_next   = bud;
          uret_next = bap_pkg::ST_F_LOOP;
          st_next   = bap_pkg::ST_U_RD;
        end
      end

      bap_pkg::ST_F_LINK: begin
        lp_next   = page;
        lo_next   = ord;
        lt_next   = 1'b0;
        lret_next = bap_pkg::ST_RESP;
        st_next   = bap_pkg::ST_L_RD;
      end

      bap_pkg::ST_U_RD: begin
        ram_raddr = up[AW-1:0];
        st_next   = bap_pkg::ST_U_GET;
      end

      bap_pkg::ST_U_GET: begin
        w.mark    = 1'b0;
        ram_we    = 1'b1;
        ram_waddr = up[AW-1:0];
        ram_wdata = w;
        upr_next  = rd.pr;
        unx_next  = rd.nx;
        if (rd.pr >= NIL) begin
          hd_we  = 1'b1;
          hd_idx = rd.tag[XW-1:0];
          hd_val = rd.nx;
        end
        if (rd.nx >= NIL) begin
          tl_we  = 1'b1;
          tl_idx = rd.tag[XW-1:0];
          tl_val = rd.pr;
        end
        if (rd.pr < NIL) begin
          st_next = bap_pkg::ST_U_PRD;
        end else if (rd.nx < NIL) begin
          st_next = bap_pkg::ST_U_NRD;
        end else begin
          st_next = uret;
        end
      end

      bap_pkg::ST_U_PRD: begin
        ram_raddr = upr[AW-1:0];
        st_next   = bap_pkg::ST_U_PWR;
      end

      bap_pkg::ST_U_PWR: begin
        w.nx      = unx;
        ram_we    = 1'b1;
        ram_waddr = upr[AW-1:0];
        ram_wdata = w;
        st_next   = (unx < NIL) ? bap_pkg::ST_U_NRD : uret;
      end

      bap_pkg::ST_U_NRD: begin
        ram_raddr = unx[AW-1:0];
        st_next   = bap_pkg::ST_U_NWR;
      end

      bap_pkg::ST_U_NWR: begin
        w.pr      = upr;
        ram_we    = 1'b1;
        ram_waddr = unx[AW-1:0];
        ram_wdata = w;
        st_next   = uret;
      end

      bap_pkg::ST_L_RD: begin
        ram_raddr = lp[AW-1:0];
        st_next   = bap_pkg::ST_L_CHK;
      end

      bap_pkg::ST_L_CHK: begin
        if (rd.mark) begin
          // Already on a list: take it off first, then come back here.
          up_next   = lp;
          uret_next = bap_pkg::ST_L_RD;
          st_next   = bap_pkg::ST_U_RD;
        end else begin
          w.mark = 1'b1;
          w.tag  = lo;
          if (lt) begin
            x      = tail[lo[XW-1:0]];
            w.nx   = NIL;
            w.pr   = x;
            tl_we  = 1'b1;
            tl_idx = lo[XW-1:0];
            tl_val = lp;
            if (x >= NIL) begin
              hd_we  = 1'b1;
              hd_idx = lo[XW-1:0];
              hd_val = lp;
            end
          end else begin
            x      = head[lo[XW-1:0]];
            w.pr   = NIL;
            w.nx   = x;
            hd_we  = 1'b1;
            hd_idx = lo[XW-1:0];
            hd_val = lp;
            if (x >= NIL) begin
              tl_we  = 1'b1;
              tl_idx = lo[XW-1:0];
              tl_val = lp;
            end
          end
          ram_we    = 1'b1;
          ram_waddr = lp[AW-1:0];
          ram_wdata = w;
          lx_next   = x;
          st_next   = (x < NIL) ? bap_pkg::ST_L_XRD : lret;
        end
      end

      bap_pkg::ST_L_XRD: begin
        ram_raddr = lx[AW-1:0];
        st_next   = bap_pkg::ST_L_XWR;
      end

      bap_pkg::ST_L_XWR: begin
        if (lt) begin
          w.nx = lp;
        end else begin
          w.pr = lp;
        end
        ram_we    = 1'b1;
        ram_waddr = lx[AW-1:0];
        ram_wdata = w;
        st_next   = lret;
      end

      bap_pkg::ST_RESP: begin
        if (!out_valid || !out_stall) begin
          out_load      = 1'b1;
          clr_init_next = 1'b0;
          st_next       = bap_pkg::ST_IDLE;
        end
      end

      default: st_next = bap_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (out_load) begin
      out_item.status       <= res_status;
      out_item.granted_page <= res_page;
    end
  end

endmodule
